// File: rtl/piecewise_cubic_spline_eval_defines.svh
// Assertion macros for the piecewise cubic spline evaluator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PIECEWISE_CUBIC_SPLINE_EVAL_DEFINES_SVH
`define PIECEWISE_CUBIC_SPLINE_EVAL_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked on every rising edge outside of reset.
`define PCSE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen on a rising edge outside of reset.
`define PCSE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PCSE_ASSERT(label, clk, rst_n, prop, msg)
`define PCSE_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: rtl/pcse_pkg.sv
// Shared types, codes and saturation helper for the spline evaluator.
// No dependencies; imported by piecewise_cubic_spline_eval and the testbench.
package pcse_pkg;

  localparam int Q_W     = 32;
  localparam int FUNC_W  = 2;
  localparam int CURVE_W = 3;
  localparam int SLOT_W  = 6;
  localparam int KC_W    = 5;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  localparam logic [KC_W-1:0] KC_RESET = 5'd16;

  localparam logic [FUNC_W-1:0] FN_LOAD_KNOT  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD_COEF  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOAD_RATE  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_EVAL       = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KLAST,
    ST_SRCH0,
    ST_SRCH,
    ST_HSET,
    ST_COEF,
    ST_MUL,
    ST_OUT
  } fsm_state_t;

  // Steps of the shared multiplier schedule
  typedef enum logic [2:0] {
    MS_Q0H,
    MS_Q0X3H,
    MS_FH1,
    MS_DH,
    MS_FH2,
    MS_RATE_D,
    MS_RATE_RES,
    MS_LAST
  } mstep_t;

  // Saturate a 34-bit signed intermediate to Q format
  function automatic q_t sat_q(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      return v[31:0];
    end else if (v[33]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

// File: rtl/piecewise_cubic_spline_eval.sv
// Piecewise cubic spline evaluator with rate residual, one shared 32x32 multiplier.
// Depends on pcse_pkg and piecewise_cubic_spline_eval_defines.svh.
//
//   channel   dir  handshake             payload
//   in_       in   in_valid / in_stall   func, curve, slot, load_value, pore_conc, bound_conc
//   out_      out  out_valid / out_stall curve_value, residual, slope, jacobian_entry
//   cfg_      in   cfg_we                cfg_wdata (knot_count)
//
// Flow: a load item goes from acceptance through ST_OUT into the output register, and the
// block takes the next item of either kind only once back in ST_IDLE. An evaluate item runs
// ST_KLAST, ST_SRCH0, P knot probes in ST_SRCH (n = knots in use, at most ceil(log2(n+1))
// probes), ST_HSET, the ST_COEF fetches and the ST_MUL steps before ST_OUT. The knot memory
// read port sets the search (one probe a cycle), the shared multiplier the Horner and rate schedule.
// Reset: synchronous, active low; clears the sequencer and output valid, knot_count to 16.
// Tables come up undefined and must be loaded before use.
// Stalls: the block takes no item while an evaluation runs; a finished result waits in the
// output register while the next item is accepted and worked on.
`include "piecewise_cubic_spline_eval_defines.svh"

module piecewise_cubic_spline_eval #(
  parameter int MAX_KNOTS  = 16,
  parameter int NUM_CURVES = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [pcse_pkg::KC_W-1:0]      cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pcse_pkg::FUNC_W-1:0]    in_func,
  input  logic [pcse_pkg::CURVE_W-1:0]   in_curve,
  input  logic [pcse_pkg::SLOT_W-1:0]    in_slot,
  input  pcse_pkg::q_t                   in_load_value,
  input  pcse_pkg::q_t                   in_pore_conc,
  input  pcse_pkg::q_t                   in_bound_conc,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output pcse_pkg::q_t                   out_curve_value,
  output pcse_pkg::q_t                   out_residual,
  output pcse_pkg::q_t                   out_slope,
  output pcse_pkg::q_t                   out_jacobian_entry
);
  import pcse_pkg::*;

  // Knot index, knot count and curve index widths
  localparam int KW = $clog2(MAX_KNOTS);
  localparam int NW = $clog2(MAX_KNOTS + 1);
  localparam int CW = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;
  localparam int KD = (2 ** CW) * (2 ** KW);
  localparam int CD = 4 * KD;
  localparam int RD = 2 ** CW;
  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // ---------------------------------------------------------------------------
  // State and registers
  // ---------------------------------------------------------------------------
  fsm_state_t          state_r, state_nxt;
  mstep_t              mstep_r;
  logic [1:0]          cnt_r;
  logic [KC_W-1:0]     kc_r;
  logic                out_valid_r;

  logic [CW-1:0]       curve_r;
  q_t                  x_r, y_r;
  logic [NW-1:0]       n_r;
  logic                zero_r;

  q_t                  k0_r, klast_r, rate_r;
  logic [NW-1:0]       first_r, count_r;
  logic [KW-1:0]       it_r, idx_r, cidx_r;
  q_t                  h_r;
  logic                edge_r;
  q_t                  q0_r, q0x3_r, q1_r, q1x2_r, q2_r, q3_r;
  q_t                  fa_r, da_r, res_r, jac_r;
  logic signed [63:0]  prod_r;

  q_t                  out_f_r, out_res_r, out_d_r, out_jac_r;

  // Memories with registered read
  q_t                  knot_mem [KD];
  q_t                  coef_mem [CD];
  q_t                  rate_mem [RD];
  q_t                  knot_rd_r, coef_rd_r, rate_rd_r;
  logic [CW+KW-1:0]    kraddr;
  logic [CW+KW+1:0]    craddr;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic                in_acc;
  logic [CW-1:0]       cin;
  logic                curve_ok;
  logic                eval_go;
  logic [KW+1:0]       slot_x;
  logic [NW-1:0]       n_c;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cin      = CW'(in_curve);
  assign curve_ok = int'(in_curve) < NUM_CURVES;
  assign eval_go  = curve_ok && (in_func == FN_EVAL);
  assign slot_x   = (KW + 2)'(in_slot);

  // Clamp the knot count into [2, MAX_KNOTS]
  always_comb begin
    if (kc_r < 5'd2) begin
      n_c = NW'(2);
    end else if (int'(kc_r) > MAX_KNOTS) begin
      n_c = NW'(MAX_KNOTS);
    end else begin
      n_c = NW'(kc_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Upper-bound search step: consume the probe issued last cycle, pick the next
  // ---------------------------------------------------------------------------
  logic [KW-1:0]       it0;
  logic [NW-1:0]       step_c, first_n, count_n;
  logic [KW-1:0]       it_n, idx_n;
  logic                ge_c;

  assign it0     = KW'(n_r >> 1);
  assign step_c  = count_r >> 1;
  assign ge_c    = !(x_r < knot_rd_r);
  assign first_n = ge_c ? (NW'(it_r) + NW'(1)) : first_r;
  assign count_n = ge_c ? (count_r - step_c - NW'(1)) : step_c;
  assign it_n    = KW'(first_n + (count_n >> 1));
  assign idx_n   = (first_n != '0) ? KW'(first_n - NW'(1)) : '0;

  // ---------------------------------------------------------------------------
  // Interval setup: h, outer-interval flags and coefficient row
  // ---------------------------------------------------------------------------
  logic                below_c, above_c;
  logic [NW-1:0]       nm2_c;
  logic [KW-1:0]       cidx_c;
  q_t                  h_c;

  assign below_c = x_r < k0_r;
  assign above_c = !below_c && !(x_r < klast_r);
  assign nm2_c   = n_r - NW'(2);
  assign h_c     = sat_q(34'(x_r) - 34'(knot_rd_r));

  always_comb begin
    if (below_c) begin
      cidx_c = '0;
    end else if (above_c) begin
      cidx_c = KW'(nm2_c);
    end else if (NW'(idx_r) > nm2_c) begin
      cidx_c = KW'(nm2_c);
    end else begin
      cidx_c = idx_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier and post unit (round half up, saturate, add or negate)
  // ---------------------------------------------------------------------------
  q_t                  mul_a, mul_b;
  logic signed [63:0]  mul_p;
  logic signed [63:0]  rnd_sh;
  q_t                  prod_q;
  q_t                  addend;
  logic                neg;
  q_t                  post_q;

  assign mul_p  = mul_a * mul_b;
  assign rnd_sh = (prod_r + RND_HALF) >>> FRAC_BITS;

  always_comb begin
    if (&rnd_sh[63:31] || ~|rnd_sh[63:31]) begin
      prod_q = rnd_sh[31:0];
    end else if (rnd_sh[63]) begin
      prod_q = Q_MIN;
    end else begin
      prod_q = Q_MAX;
    end
  end

  // Operand and addend selection per schedule step. Outer intervals run the
  // cubic schedule with the cubic term forced to zero.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    addend = '0;
    neg    = 1'b0;
    if (state_r == ST_MUL) begin
      unique case (mstep_r)
        MS_Q0H: begin
          mul_a = q0_r;
          mul_b = h_r;
        end
        MS_Q0X3H: begin
          mul_a  = q0x3_r;
          mul_b  = h_r;
          addend = q1_r;
        end
        MS_FH1: begin
          mul_a  = fa_r;
          mul_b  = h_r;
          addend = q1x2_r;
        end
        MS_DH: begin
          mul_a  = da_r;
          mul_b  = h_r;
          addend = q2_r;
        end
        MS_FH2: begin
          mul_a  = fa_r;
          mul_b  = h_r;
          addend = q2_r;
        end
        MS_RATE_D: begin
          mul_a  = rate_r;
          mul_b  = da_r;
          addend = q3_r;
        end
        MS_RATE_RES: begin
          mul_a = rate_r;
          mul_b = sat_q(34'(y_r) - 34'(fa_r));
          neg   = 1'b1;
        end
        MS_LAST: begin
          addend = '0;
        end
        default: begin
          addend = '0;
        end
      endcase
    end
  end

  assign post_q = sat_q(34'(addend) + (neg ? -34'(prod_q) : 34'(prod_q)));

  // ---------------------------------------------------------------------------
  // Sequencer: next state and memory read addresses
  // ---------------------------------------------------------------------------
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    kraddr    = '0;
    craddr    = '0;
    unique case (state_r)
      ST_IDLE: begin
        // Fetch knot 0 while the item is taken
        kraddr = {cin, KW'(0)};
        if (in_acc) begin
          state_nxt = eval_go ? ST_KLAST : ST_OUT;
        end
      end
      ST_KLAST: begin
        kraddr    = {curve_r, KW'(n_r - NW'(1))};
        state_nxt = ST_SRCH0;
      end
      ST_SRCH0: begin
        kraddr    = {curve_r, it0};
        state_nxt = ST_SRCH;
      end
      ST_SRCH: begin
        if (count_n != '0) begin
          kraddr = {curve_r, it_n};
        end else begin
          // Search done: fetch the knot that h is measured from
          kraddr    = {curve_r, idx_n};
          state_nxt = ST_HSET;
        end
      end
      ST_HSET: begin
        craddr    = {curve_r, cidx_c, 2'd0};
        state_nxt = ST_COEF;
      end
      ST_COEF: begin
        craddr = {curve_r, cidx_r, cnt_r + 2'd1};
        if (cnt_r == 2'd3) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mstep_r == MS_LAST) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output register can take the result
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mstep_r     <= MS_Q0H;
      cnt_r       <= '0;
      kc_r        <= KC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        kc_r <= cfg_wdata;
      end
      if (state_r == ST_HSET) begin
        cnt_r <= '0;
      end else if (state_r == ST_COEF) begin
        cnt_r <= cnt_r + 2'd1;
      end
      if (state_r == ST_COEF) begin
        mstep_r <= MS_Q0H;
      end else if (state_r == ST_MUL) begin
        mstep_r <= mstep_t'(3'(mstep_r) + 3'd1);
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tables: write on accepted load items, registered reads every cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc && curve_ok) begin
      if (in_func == FN_LOAD_KNOT && int'(in_slot) < MAX_KNOTS) begin
        knot_mem[{cin, slot_x[KW-1:0]}] <= in_load_value;
      end
      if (in_func == FN_LOAD_COEF && int'(in_slot) < 4 * MAX_KNOTS) begin
        coef_mem[{cin, slot_x}] <= in_load_value;
      end
      if (in_func == FN_LOAD_RATE) begin
        rate_mem[cin] <= in_load_value;
      end
    end
    knot_rd_r <= knot_mem[kraddr];
    coef_rd_r <= coef_mem[craddr];
    rate_rd_r <= rate_mem[cin];
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (in_acc) begin
      curve_r <= cin;
      x_r     <= in_pore_conc;
      y_r     <= in_bound_conc;
      n_r     <= n_c;
      zero_r  <= !eval_go;
    end
    unique case (state_r)
      ST_KLAST: begin
        k0_r   <= knot_rd_r;
        rate_r <= rate_rd_r;
      end
      ST_SRCH0: begin
        klast_r <= knot_rd_r;
        first_r <= '0;
        count_r <= n_r;
        it_r    <= it0;
      end
      ST_SRCH: begin
        first_r <= first_n;
        count_r <= count_n;
        it_r    <= it_n;
        idx_r   <= idx_n;
      end
      ST_HSET: begin
        h_r    <= h_c;
        cidx_r <= cidx_c;
        edge_r <= below_c || above_c;
      end
      ST_COEF: begin
        unique case (cnt_r)
          2'd0: begin
            q0_r   <= edge_r ? '0 : coef_rd_r;
            q0x3_r <= edge_r ? '0 : sat_q((34'(coef_rd_r) <<< 1) + 34'(coef_rd_r));
          end
          2'd1: begin
            q1_r   <= coef_rd_r;
            q1x2_r <= sat_q(34'(coef_rd_r) <<< 1);
          end
          2'd2: q2_r <= coef_rd_r;
          2'd3: q3_r <= coef_rd_r;
          default: q3_r <= coef_rd_r;
        endcase
      end
      ST_MUL: begin
        // Post the product issued in the previous step
        unique case (mstep_r)
          MS_Q0X3H:    fa_r  <= post_q;
          MS_FH1:      da_r  <= post_q;
          MS_DH:       fa_r  <= post_q;
          MS_FH2:      da_r  <= post_q;
          MS_RATE_D:   fa_r  <= post_q;
          MS_RATE_RES: jac_r <= post_q;
          MS_LAST:     res_r <= post_q;
          default:     res_r <= res_r;
        endcase
      end
      default: begin
        it_r <= it_r;
      end
    endcase
    if (state_r == ST_OUT && out_free) begin
      out_f_r   <= zero_r ? '0 : fa_r;
      out_res_r <= zero_r ? '0 : res_r;
      out_d_r   <= zero_r ? '0 : da_r;
      out_jac_r <= zero_r ? '0 : jac_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_curve_value    = out_f_r;
  assign out_residual       = out_res_r;
  assign out_slope          = out_d_r;
  assign out_jacobian_entry = out_jac_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PCSE_ASSERT(a_valid_from_out, clk, rst_n, $rose(out_valid_r) |-> $past(state_r) == ST_OUT, "result raised outside the output state")
  `PCSE_ASSERT(a_search_bounds, clk, rst_n, (state_r == ST_SRCH) |-> ((NW+1)'(first_r) + (NW+1)'(count_r) <= (NW+1)'(n_r)), "search window beyond knots in use")
  `PCSE_ASSERT(a_out_hold, clk, rst_n, (state_r == ST_OUT && out_valid_r && out_stall) |=> (state_r == ST_OUT), "result dropped while output stalled")
  `PCSE_ASSERT(a_mul_start, clk, rst_n, (state_r == ST_COEF && state_nxt == ST_MUL) |=> (mstep_r == MS_Q0H), "multiplier schedule not restarted")
  `PCSE_ASSERT_NEVER(a_coef_count, clk, rst_n, (state_r == ST_MUL) && $past(state_r) == ST_COEF && $past(cnt_r) != 2'd3, "coefficient fetch cut short")

endmodule

// File: sim/testbench.sv
// Self-checking testbench for piecewise_cubic_spline_eval: loads curve tables, evaluates
// splines under varying knot counts and handshake pressure, checks every result item.
// Depends on pcse_pkg and the RTL of the block; nothing else.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcse_pkg::*;

  localparam int MAX_KNOTS    = 16;
  localparam int NUM_CURVES   = 8;
  localparam int FRAC_BITS    = 16;
  localparam int COEF_SPAN    = 4 * MAX_KNOTS;
  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 10;
  // Idle stretch after the last result is due; gives the tail some slack.
  localparam int DRAIN_CYCLES = 30;
  localparam int SETTLE_CAP   = 50000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 160;
  localparam int NUM_PHASES   = 8;
  localparam longint LIMIT_CYCLES = 600000;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [CURVE_W-1:0] curve;
    logic [SLOT_W-1:0]  slot;
    q_t                 load_value;
    q_t                 pore_conc;
    q_t                 bound_conc;
  } spline_item_t;

  typedef struct packed {
    q_t curve_value;
    q_t residual;
    q_t slope;
    q_t jacobian_entry;
  } spline_out_t;

  // Scoreboard: keeps its own copy of the curve tables and knot count, works out the
  // result each accepted item must give, and matches results in order.
  class spline_scoreboard;
    q_t              knot_mem[NUM_CURVES*MAX_KNOTS];
    q_t              coef_mem[NUM_CURVES*COEF_SPAN];
    q_t              rate_mem[NUM_CURVES];
    logic [KC_W-1:0] knots_in_use;
    spline_out_t     outs_due[$];
    int unsigned     mismatches;

    function new();
      foreach (knot_mem[i]) knot_mem[i] = '0;
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (rate_mem[i]) rate_mem[i] = '0;
      knots_in_use = KC_RESET;
      mismatches = 0;
    endfunction

    function q_t sat(longint v);
      if (v > 64'sd2147483647) return Q_MAX;
      if (v < -64'sd2147483648) return Q_MIN;
      return q_t'(v[31:0]);
    endfunction

    // Exact product, round half up, floor shift, then clamp.
    function q_t mul(q_t a, q_t b);
      longint p;
      p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC_BITS - 1));
      return sat(p >>> FRAC_BITS);
    endfunction

    function q_t add(q_t a, q_t b);
      return sat(longint'(a) + longint'(b));
    endfunction

    function q_t scale(q_t a, int k);
      return sat(longint'(a) * k);
    endfunction

    function void report(string msg);
      if (mismatches < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endfunction

    function void set_count(logic [KC_W-1:0] v);
      knots_in_use = v;
    endfunction

    // Apply a load, or evaluate f, rate*(y-f), f' and -rate*f' for one curve.
    function spline_out_t predict_outputs(spline_item_t it);
      spline_out_t r;
      int kb, cb, n, np, first, count, half, probe, idx, qb;
      q_t x, h, f, d, rate;
      r = '0;
      kb = int'(it.curve) * MAX_KNOTS;
      cb = int'(it.curve) * COEF_SPAN;
      case (it.func)
        FN_LOAD_KNOT: if (it.slot < MAX_KNOTS) knot_mem[kb + int'(it.slot)] = it.load_value;
        FN_LOAD_COEF: if (it.slot < COEF_SPAN) coef_mem[cb + int'(it.slot)] = it.load_value;
        FN_LOAD_RATE: rate_mem[it.curve] = it.load_value;
        default: begin
          x = it.pore_conc;
          rate = rate_mem[it.curve];
          n = int'(knots_in_use);
          if (n < 2) n = 2;
          if (n > MAX_KNOTS) n = MAX_KNOTS;
          np = 4 * (n - 1);
          // upper-bound search over the knots in use, then step back one
          first = 0;
          count = n;
          while (count > 0) begin
            half = count / 2;
            probe = first + half;
            if (!(x < knot_mem[kb + probe])) begin
              first = probe + 1;
              count -= half + 1;
            end else begin
              count = half;
            end
          end
          idx = (first > 0) ? first - 1 : 0;
          h = sat(longint'(x) - longint'(knot_mem[kb + idx]));
          if (x < knot_mem[kb]) begin
            f = add(mul(add(mul(coef_mem[cb+1], h), coef_mem[cb+2]), h), coef_mem[cb+3]);
            d = add(mul(scale(coef_mem[cb+1], 2), h), coef_mem[cb+2]);
          end else if (x >= knot_mem[kb + n - 1]) begin
            qb = cb + np;
            f = add(mul(add(mul(coef_mem[qb-3], h), coef_mem[qb-2]), h), coef_mem[qb-1]);
            d = add(mul(scale(coef_mem[qb-3], 2), h), coef_mem[qb-2]);
          end else begin
            if (idx > n - 2) idx = n - 2;
            qb = cb + 4 * idx;
            f = add(mul(add(mul(add(mul(coef_mem[qb], h), coef_mem[qb+1]), h),
                                coef_mem[qb+2]), h), coef_mem[qb+3]);
            d = add(mul(add(mul(scale(coef_mem[qb], 3), h), scale(coef_mem[qb+1], 2)), h),
                    coef_mem[qb+2]);
          end
          r.curve_value    = f;
          r.residual       = mul(rate, sat(longint'(it.bound_conc) - longint'(f)));
          r.slope          = d;
          r.jacobian_entry = sat(-longint'(mul(rate, d)));
        end
      endcase
      return r;
    endfunction

    function void take_item(spline_item_t it);
      outs_due = {outs_due, predict_outputs(it)};
    endfunction

    function void compare_field(string name, q_t got, q_t want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endfunction

    function void match_result(spline_out_t got);
      spline_out_t want;
      if (outs_due.size() == 0) begin
        report("result item with nothing outstanding");
        return;
      end
      want = outs_due.pop_front();
      compare_field("curve_value", got.curve_value, want.curve_value);
      compare_field("residual", got.residual, want.residual);
      compare_field("slope", got.slope, want.slope);
      compare_field("jacobian_entry", got.jacobian_entry, want.jacobian_entry);
    endfunction

    function void close_out();
      if (outs_due.size() != 0)
        report($sformatf("%0d result items never arrived", outs_due.size()));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [KC_W-1:0]    cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  in_func = '0;
  logic [CURVE_W-1:0] in_curve = '0;
  logic [SLOT_W-1:0]  in_slot = '0;
  q_t                 in_load_value = '0;
  q_t                 in_pore_conc = '0;
  q_t                 in_bound_conc = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  q_t                 out_curve_value;
  q_t                 out_residual;
  q_t                 out_slope;
  q_t                 out_jacobian_entry;

  spline_scoreboard sb = new();

  // Stimulus-side view: knots as sent (to aim x at intervals), current knot count,
  // and the idling knobs shared with the receiver process.
  q_t              knot_shadow[NUM_CURVES][MAX_KNOTS];
  logic [KC_W-1:0] kc_now = KC_RESET;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  bit              hold_req = 1'b0;
  int              hold_left = 0;
  int              items_sent = 0;

  piecewise_cubic_spline_eval #(
    .MAX_KNOTS  (MAX_KNOTS),
    .NUM_CURVES (NUM_CURVES),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_curve           (in_curve),
    .in_slot            (in_slot),
    .in_load_value      (in_load_value),
    .in_pore_conc       (in_pore_conc),
    .in_bound_conc      (in_bound_conc),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_curve_value    (out_curve_value),
    .out_residual       (out_residual),
    .out_slope          (out_slope),
    .out_jacobian_entry (out_jacobian_entry)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs or the handshake deadlocks.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d result items outstanding", sb.outs_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: stall at the phase rate; on request, hold off for a long counted stretch
  // so that the block backs up into its input.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: sample handshakes at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_count(cfg_wdata);
      if (in_valid && !in_stall)
        sb.take_item('{func: in_func, curve: in_curve, slot: in_slot,
                       load_value: in_load_value, pore_conc: in_pore_conc,
                       bound_conc: in_bound_conc});
      if (out_valid && !out_stall)
        sb.match_result('{curve_value: out_curve_value, residual: out_residual,
                          slope: out_slope, jacobian_entry: out_jacobian_entry});
    end
  end

  function automatic int in_use_count();
    int n;
    n = int'(kc_now);
    if (n < 2) n = 2;
    if (n > MAX_KNOTS) n = MAX_KNOTS;
    return n;
  endfunction

  // Mix of full-range words, corner values, small and medium magnitudes.
  function automatic q_t rand_fixed();
    q_t v;
    case ($urandom_range(7))
      0, 1: v = q_t'($urandom);
      2: begin
        case ($urandom_range(4))
          0: v = Q_MIN;
          1: v = Q_MAX;
          2: v = '0;
          3: v = '1;
          default: v = q_t'(32'sh0001_0000);
        endcase
      end
      3, 4, 5: v = q_t'(int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
      default: v = q_t'(int'($urandom_range(0, 32'h100_0000)) - 32'sh80_0000);
    endcase
    return v;
  endfunction

  // Aim x below, on, between or past the knots in use, or anywhere at all.
  function automatic q_t pick_abscissa(int c);
    int n, i;
    longint lo, span;
    q_t v;
    n = in_use_count();
    i = $urandom_range(0, n - 1);
    case ($urandom_range(9))
      0: v = q_t'($urandom);
      1: v = $urandom_range(1) ? Q_MIN : Q_MAX;
      2: v = sb.sat(longint'(knot_shadow[c][0]) - longint'($urandom_range(1, 32'h4_0000)));
      3: v = sb.sat(longint'(knot_shadow[c][n-1]) + longint'($urandom_range(0, 32'h4_0000)));
      4, 5: v = knot_shadow[c][i];
      default: begin
        if (i == n - 1) i = n - 2;
        lo = longint'(knot_shadow[c][i]);
        span = longint'(knot_shadow[c][i+1]) - lo;
        v = (span > 0) ? q_t'(lo + longint'($urandom) % span) : q_t'(lo);
      end
    endcase
    return v;
  endfunction

  function automatic spline_item_t mk_item(logic [FUNC_W-1:0] fn, int c, int s, q_t lv,
                                           q_t x, q_t y);
    spline_item_t it;
    it.func       = fn;
    it.curve      = c[CURVE_W-1:0];
    it.slot       = s[SLOT_W-1:0];
    it.load_value = lv;
    it.pore_conc  = x;
    it.bound_conc = y;
    return it;
  endfunction

  // Offer one item after a random gap and hold it until accepted.
  task automatic offer(input spline_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= it.func;
    in_curve      <= it.curve;
    in_slot       <= it.slot;
    in_load_value <= it.load_value;
    in_pore_conc  <= it.pore_conc;
    in_bound_conc <= it.bound_conc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.func == FN_LOAD_KNOT && it.slot < MAX_KNOTS)
      knot_shadow[it.curve][it.slot] = it.load_value;
    items_sent++;
  endtask

  task automatic offer_load(logic [FUNC_W-1:0] fn, int c, int s, q_t lv);
    offer(mk_item(fn, c, s, lv, q_t'($urandom), q_t'($urandom)));
  endtask

  task automatic offer_eval(int c, q_t x, q_t y);
    offer(mk_item(FN_EVAL, c, $urandom_range(63), q_t'($urandom), x, y));
  endtask

  // Knot set styles: 0 wide sorted, 1 narrow strictly rising, 2 unsorted,
  // 3 sorted with the range ends and a repeated knot.
  task automatic load_knot_set(int c, int style);
    q_t pts[MAX_KNOTS];
    q_t t;
    longint acc;
    int a, b;
    if (style == 1) begin
      acc = longint'($urandom_range(0, 32'h10_0000)) - 64'sh8_0000;
      for (a = 0; a < MAX_KNOTS; a++) begin
        pts[a] = q_t'(acc);
        acc += longint'($urandom_range(1, 32'h2_0000));
      end
    end else begin
      for (a = 0; a < MAX_KNOTS; a++) pts[a] = rand_fixed();
      if (style == 3) begin
        pts[0] = Q_MIN;
        pts[MAX_KNOTS-1] = Q_MAX;
        pts[5] = pts[4];
      end
      if (style != 2) begin
        for (a = 0; a < MAX_KNOTS - 1; a++)
          for (b = 0; b < MAX_KNOTS - 1 - a; b++)
            if (pts[b] > pts[b+1]) begin
              t = pts[b];
              pts[b] = pts[b+1];
              pts[b+1] = t;
            end
      end
    end
    for (a = 0; a < MAX_KNOTS; a++) offer_load(FN_LOAD_KNOT, c, a, pts[a]);
  endtask

  task automatic load_curve(int c, int style);
    int s;
    load_knot_set(c, style);
    for (s = 0; s < COEF_SPAN; s++) offer_load(FN_LOAD_COEF, c, s, rand_fixed());
    offer_load(FN_LOAD_RATE, c, $urandom_range(63), rand_fixed());
  endtask

  // The caller must issue config writes only while the block is empty; neither this task nor the block enforces it.
  task automatic write_knot_count(logic [KC_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    kc_now = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline go quiet.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outs_due.size() != 0 && waited < SETTLE_CAP) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default: begin send_idle_pct = 34; recv_stall_pct = 34; end
    endcase
  endtask

  // Corners first: ignored knot slots, the top coefficient slot, rate extremes and x
  // below, on and past the knots of the narrow curve, then the odd-shaped curves.
  task automatic directed_items();
    offer_load(FN_LOAD_KNOT, 0, MAX_KNOTS, Q_MAX);
    offer_load(FN_LOAD_KNOT, 0, 63, Q_MIN);
    offer_load(FN_LOAD_COEF, 7, 63, Q_MIN);
    offer_load(FN_LOAD_RATE, 0, 63, Q_MAX);
    offer_eval(0, Q_MIN, Q_MAX);
    offer_eval(0, Q_MAX, Q_MIN);
    offer_eval(0, knot_shadow[0][0], '0);
    offer_eval(0, knot_shadow[0][MAX_KNOTS-1], q_t'(32'sh0001_0000));
    offer_eval(0, knot_shadow[0][7], rand_fixed());
    offer_eval(0, knot_shadow[0][3] + 1, rand_fixed());
    offer_load(FN_LOAD_RATE, 0, 0, Q_MIN);
    offer_eval(0, knot_shadow[0][1], Q_MAX);
    offer_eval(0, knot_shadow[0][0] - 1, Q_MIN);
    offer_load(FN_LOAD_RATE, 0, 0, '0);
    offer_eval(0, '1, '1);
    offer_load(FN_LOAD_RATE, 0, 0, q_t'(32'sh0001_0000));
    offer_load(FN_LOAD_COEF, 0, 0, Q_MAX);
    offer_load(FN_LOAD_COEF, 0, 1, Q_MIN);
    offer_eval(0, knot_shadow[0][0] + 1, rand_fixed());
    offer_eval(2, Q_MAX, Q_MIN);
    offer_eval(2, Q_MIN, Q_MAX);
    offer_eval(1, '0, '0);
  endtask

  // Mostly evaluations on loaded curves; now and then reshape knots, rewrite an
  // interval, change a rate, or send a stray load (some to knot slots that are ignored).
  task automatic random_traffic(int budget);
    int stop_at, r, c, s, j;
    logic [FUNC_W-1:0] fn;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      c = $urandom_range(NUM_CURVES - 1);
      if (r < 4) begin
        load_knot_set(c, $urandom_range(3));
      end else if (r < 9) begin
        s = 4 * $urandom_range(MAX_KNOTS - 1);
        for (j = 0; j < 4; j++) offer_load(FN_LOAD_COEF, c, s + j, rand_fixed());
      end else if (r < 13) begin
        offer_load(FN_LOAD_RATE, c, $urandom_range(63), rand_fixed());
      end else if (r < 17) begin
        fn = FUNC_W'($urandom_range(2));
        offer_load(fn, c, $urandom_range(63), rand_fixed());
      end else begin
        offer_eval(c, pick_abscissa(c), rand_fixed());
      end
    end
  endtask

  initial begin
    logic [KC_W-1:0] kc_plan[NUM_PHASES];
    int c, p;
    // Sweep the count through its clamps: both extremes, the floor, above the ceiling.
    kc_plan = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd1, 5'd9, 5'd17, 5'd16};
    kc_plan[NUM_PHASES-1] = KC_W'($urandom_range(31));
    foreach (knot_shadow[a, b]) knot_shadow[a][b] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every table entry an evaluation may read before any evaluation runs.
    set_idling(0);
    write_knot_count(KC_RESET);
    for (c = 0; c < NUM_CURVES; c++) load_curve(c, (c + 1) % 4);
    directed_items();

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_knot_count(kc_plan[p]);
      set_idling(p % 4);
      // Back up the block at least twice with the sender running flat out.
      if (p == 0 || p == 4) hold_req = 1'b1;
      random_traffic(PHASE_ITEMS);
    end

    settle();
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: piecewise_cubic_spline_eval.f
+incdir+rtl
rtl/pcse_pkg.sv
rtl/piecewise_cubic_spline_eval.sv
sim/testbench.sv
